// ===== rtl/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Types and constants shared by the sensor channel confidence unit.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

   localparam int unsigned NUM_TRACKED = 7;
   localparam int unsigned IDX_W       = 3;

   localparam logic [15:0] CONF_ONE      = 16'd32768;
   localparam logic [15:0] CONF_STEP     = 16'd328;
   localparam logic signed [31:0] SEA_LEVEL_Q10 = 32'sd103756800;

   // Channel codes.
   localparam logic [3:0] CH_GYRO_FIRST = 4'd3;
   localparam logic [3:0] CH_BARO       = 4'd6;
   localparam logic [3:0] CH_MAG        = 4'd7;
   localparam logic [3:0] CH_GPS        = 4'd8;

   // Register indexes.
   localparam logic [2:0] CSR_TIMEOUT    = 3'd0;
   localparam logic [2:0] CSR_PENALTY    = 3'd1;
   localparam logic [2:0] CSR_MIN_VALID  = 3'd2;
   localparam logic [2:0] CSR_SPIKE_ACC  = 3'd3;
   localparam logic [2:0] CSR_SPIKE_GYRO = 3'd4;
   localparam logic [2:0] CSR_SPIKE_BARO = 3'd5;

   typedef struct packed {
      logic [3:0]         channel;
      logic signed [31:0] sample_value;
      logic [31:0]        group_time;
      logic [31:0]        current_time;
      logic               fix_ok;
   } req_type;

   typedef struct packed {
      logic [3:0]  result_channel;
      logic [15:0] confidence;
   } rsp_type;

   typedef struct packed {
      logic [31:0] timeout_limit;
      logic [15:0] penalty_factor;
      logic [15:0] min_valid;
      logic [31:0] spike_limit_acc;
      logic [31:0] spike_limit_gyro;
      logic [31:0] spike_limit_baro;
   } cfg_type;

   // State update from the datapath to the channel store.
   typedef struct packed {
      logic        write_conf;
      logic        write_last;
      logic [15:0] conf;
   } upd_type;

endpackage

`default_nettype wire

// ===== rtl/scc_chan_state.sv =====
// ----------------------------------------------------------------------------
// scc_chan_state
// Per-channel last good value and running confidence for the tracked channels.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_chan_state (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [scc_pkg::IDX_W-1:0]         idx,
   output logic signed [31:0]                     last_value,
   output logic [15:0]                            last_conf,
   input  wire logic                              update_en,
   input  wire scc_pkg::upd_type                  upd,
   input  wire logic signed [31:0]                new_value
);

   logic signed [31:0] last_ff [scc_pkg::NUM_TRACKED];
   logic [15:0]        conf_ff [scc_pkg::NUM_TRACKED];

   logic idx_ok;
   assign idx_ok = ({1'b0, idx} < 4'(scc_pkg::NUM_TRACKED));

   always_comb begin
      last_value = '0;
      last_conf  = '0;
      if (idx_ok) begin
         last_value = last_ff[idx];
         last_conf  = conf_ff[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scc_pkg::NUM_TRACKED; i++) begin
            last_ff[i] <= (i == int'(scc_pkg::CH_BARO)) ? scc_pkg::SEA_LEVEL_Q10 : '0;
            conf_ff[i] <= '0;
         end
      end else if (update_en && idx_ok) begin
         if (upd.write_conf) begin
            conf_ff[idx] <= upd.conf;
         end
         if (upd.write_last) begin
            last_ff[idx] <= new_value;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scc_conf_calc.sv =====
// ----------------------------------------------------------------------------
// scc_conf_calc
// Timeout, spike check and confidence update for one registered sample.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_conf_calc (
   input  wire scc_pkg::req_type     req,
   input  wire scc_pkg::cfg_type     cfg,
   input  wire logic signed [31:0]   last_value,
   input  wire logic [15:0]          last_conf,
   output scc_pkg::upd_type          upd,
   output logic [15:0]               confidence
);

   logic [31:0]        age;
   logic               late;
   logic [31:0]        limit;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic               spike;
   logic [31:0]        prod;
   logic [16:0]        inc;
   logic [15:0]        tracked_conf;
   logic [15:0]        raw_conf;

   assign age  = req.current_time - req.group_time;
   assign late = (age > cfg.timeout_limit);

   always_comb begin
      if (req.channel < scc_pkg::CH_GYRO_FIRST) begin
         limit = cfg.spike_limit_acc;
      end else if (req.channel < scc_pkg::CH_BARO) begin
         limit = cfg.spike_limit_gyro;
      end else begin
         limit = cfg.spike_limit_baro;
      end
   end

   // Exact 33-bit difference, so a jump across the full range never wraps.
   assign diff  = {req.sample_value[31], req.sample_value} - {last_value[31], last_value};
   assign mag   = diff[32] ? 33'(-diff) : 33'(diff);
   assign spike = (mag > {1'b0, limit});

   assign prod = last_conf * cfg.penalty_factor;
   assign inc  = {1'b0, last_conf} + {1'b0, scc_pkg::CONF_STEP};

   always_comb begin
      if (spike) begin
         raw_conf = prod[31:16];
      end else if (inc > {1'b0, scc_pkg::CONF_ONE}) begin
         raw_conf = scc_pkg::CONF_ONE;
      end else begin
         raw_conf = inc[15:0];
      end
   end

   always_comb begin
      if (late) begin
         tracked_conf = '0;
      end else if (raw_conf < cfg.min_valid) begin
         tracked_conf = '0;
      end else begin
         tracked_conf = raw_conf;
      end
   end

   always_comb begin
      upd.write_conf = 1'b0;
      upd.write_last = 1'b0;
      upd.conf       = tracked_conf;
      if (req.channel == scc_pkg::CH_MAG) begin
         confidence = late ? 16'd0 : scc_pkg::CONF_ONE;
      end else if (req.channel == scc_pkg::CH_GPS) begin
         confidence = (late || !req.fix_ok) ? 16'd0 : scc_pkg::CONF_ONE;
      end else begin
         confidence     = tracked_conf;
         upd.write_conf = (req.channel < scc_pkg::CH_MAG);
         upd.write_last = (req.channel < scc_pkg::CH_MAG) && !late && !spike;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sensor_channel_confidence_unit.sv =====
// An accepted request passes the request register, then the result register.
// Throughput: one request per cycle; the input stalls only while a result waits in
// the result register under a receiver stall. The per-channel state written by one
// request is read by the next in the following cycle through the single stage.
// Reset is synchronous and active high; it restores the register defaults, clears
// all confidences and sets the pressure channel's last value to sea level.
// ----------------------------------------------------------------------------
// sensor_channel_confidence_unit
// Top level: request register, confidence datapath, channel store, result
// register and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_channel_confidence_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire scc_pkg::req_type  req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output scc_pkg::rsp_type       rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [31:0]       csr_data
);

   scc_pkg::cfg_type cfg_ff;
   scc_pkg::req_type s1_ff;
   logic             s1_valid_ff;
   scc_pkg::rsp_type out_ff;
   logic             out_valid_ff;

   logic               out_free;
   logic               chan_ok;
   logic               s1_fire;
   logic signed [31:0] last_value;
   logic [15:0]        last_conf;
   logic [15:0]        confidence;
   scc_pkg::upd_type   upd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_limit    <= 32'd100000;
         cfg_ff.penalty_factor   <= 16'd32768;
         cfg_ff.min_valid        <= 16'd3277;
         cfg_ff.spike_limit_acc  <= 32'd51200;
         cfg_ff.spike_limit_gyro <= 32'd10240;
         cfg_ff.spike_limit_baro <= 32'd512000;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            scc_pkg::CSR_TIMEOUT:    cfg_ff.timeout_limit    <= csr_data;
            scc_pkg::CSR_PENALTY:    cfg_ff.penalty_factor   <= csr_data[15:0];
            scc_pkg::CSR_MIN_VALID:  cfg_ff.min_valid        <= csr_data[15:0];
            scc_pkg::CSR_SPIKE_ACC:  cfg_ff.spike_limit_acc  <= csr_data;
            scc_pkg::CSR_SPIKE_GYRO: cfg_ff.spike_limit_gyro <= csr_data;
            scc_pkg::CSR_SPIKE_BARO: cfg_ff.spike_limit_baro <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Requests for channels past GPS leave the stage without a result.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign chan_ok   = (s1_ff.channel <= scc_pkg::CH_GPS);
   assign s1_fire   = s1_valid_ff && (!chan_ok || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_ff <= req_payload;
      end
   end

   scc_chan_state u_state (
      .clock      (clock),
      .reset      (reset),
      .idx        (s1_ff.channel[scc_pkg::IDX_W-1:0]),
      .last_value (last_value),
      .last_conf  (last_conf),
      .update_en  (s1_fire && chan_ok),
      .upd        (upd),
      .new_value  (s1_ff.sample_value)
   );

   scc_conf_calc u_calc (
      .req        (s1_ff),
      .cfg        (cfg_ff),
      .last_value (last_value),
      .last_conf  (last_conf),
      .upd        (upd),
      .confidence (confidence)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_fire && chan_ok) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && chan_ok) begin
         out_ff.result_channel <= s1_ff.channel;
         out_ff.confidence     <= confidence;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire
